FILE: src/printable_string_run_detector_unit_defines.svh
// Assertion macros shared by the printable string run detector RTL.
// Depends on nothing; the using module supplies clk and rst_n.
`ifndef PRINTABLE_STRING_RUN_DETECTOR_UNIT_DEFINES_SVH
`define PRINTABLE_STRING_RUN_DETECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PRSD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PRSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRSD_ASSERT_IMPL(label, ante, cons)
`define PRSD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/prsd_pkg.sv
// Shared constants, types and register indexes of the printable string run detector.
// Depends on nothing; used by prsd_char_class and the top level.
package prsd_pkg;

  // Run length limit and the widths that follow from it.
  localparam int MAX_RUN_LENGTH = 256;
  localparam int LEN_W          = $clog2(MAX_RUN_LENGTH + 1);

  // Fixed field widths.
  localparam int ADDR_W      = 32;
  localparam int STR_LEN_W   = 9;
  localparam int MIN_LEN_W   = 9;
  localparam int MIN_LET_W   = 9;
  localparam int PCT_W       = 7;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int CMP_W       = (LEN_W > MIN_LEN_W) ? LEN_W : MIN_LEN_W;
  localparam int PROD_W      = LEN_W + PCT_W;

  // Printable range and the percent scale.
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;
  localparam logic [PCT_W-1:0]  PERCENT_SCALE = 7'd100;

  // Type-descriptor name prefixes, first byte in the low bits.
  localparam int PREFIX_BYTES = 4;
  localparam logic [31:0] RTTI_CLASS_TAG  = 32'h5641_3F2E;
  localparam logic [31:0] RTTI_STRUCT_TAG = 32'h5541_3F2E;

  // Register reset values.
  localparam logic [ADDR_W-1:0]    BASE_ADDRESS_RST   = '0;
  localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RST     = 9'd6;
  localparam logic [MIN_LET_W-1:0] MIN_LETTERS_RST    = 9'd3;
  localparam logic [PCT_W-1:0]     USEFUL_PERCENT_RST = 7'd70;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS   = 2'd0,
    CFG_MIN_LENGTH     = 2'd1,
    CFG_MIN_LETTERS    = 2'd2,
    CFG_USEFUL_PERCENT = 2'd3
  } cfg_reg_t;

  // Character class flags of one byte.
  typedef struct packed {
    logic printable;
    logic letter;
    logic useful;
  } char_class_t;

endpackage

FILE: src/printable_string_run_detector_unit.sv
// Printable string run detector top level; depends on prsd_pkg and prsd_char_class.
// A result, if any, is loaded into the output register when its item advances out
// of the input register, which holds while an untaken result fills the output register.
// Throughput: one item per clock while the output side takes results; the
// output register stalls the input stage only when a result is left untaken.
// Reset (rst_n, synchronous, active low) clears all runs and restores register defaults.
module printable_string_run_detector_unit
  import prsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input bytes.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,    // [7:0] data_byte
  input  logic                   in_tlast,    // last_byte
  // Reported runs.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [31:0] string_address, [40:32] string_length
  output logic                   out_tuser,   // [0] is_rtti
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "printable_string_run_detector_unit_defines.svh"

  // Configuration registers.
  logic [ADDR_W-1:0]    base_address_r;
  logic [MIN_LEN_W-1:0] min_length_r;
  logic [MIN_LET_W-1:0] min_letters_r;
  logic [PCT_W-1:0]     useful_percent_r;

  // Input stage.
  logic              s_valid_r;
  logic [BYTE_W-1:0] s_byte_r;
  logic              s_last_r;

  // Run state.
  logic [ADDR_W-1:0] byte_offset_r;
  logic [ADDR_W-1:0] run_start_r;
  logic [LEN_W-1:0]  run_len_r;
  logic [LEN_W-1:0]  letter_cnt_r;
  logic [LEN_W-1:0]  useful_cnt_r;
  logic [31:0]       prefix_r;

  // Output register.
  logic                 out_valid_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [STR_LEN_W-1:0] out_len_r;
  logic                 out_rtti_r;

  // Datapath.
  char_class_t      cls;
  logic             adv;
  logic             start_now;
  logic             hit_max;
  logic             close_run;
  logic             qualifies;
  logic             report;
  logic             rtti;
  logic [LEN_W-1:0] len_inc;
  logic [LEN_W-1:0] j_len;
  logic [LEN_W-1:0] j_let;
  logic [LEN_W-1:0] j_use;
  logic [ADDR_W-1:0] j_start;
  logic [31:0]       j_prefix;
  logic [PROD_W-1:0] use_scaled;
  logic [PROD_W-1:0] len_scaled;

  prsd_char_class u_char_class (
    .byte_i (s_byte_r),
    .cls_o  (cls)
  );

  // The stage moves whenever the output register is free or being emptied.
  assign adv       = s_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s_valid_r || !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // Run values as they stand after this byte is taken in.
  always_comb begin
    start_now = cls.printable && (run_len_r == '0);
    len_inc   = run_len_r + LEN_W'(1);
    j_len     = cls.printable ? len_inc : run_len_r;
    j_let     = letter_cnt_r + LEN_W'(cls.printable && cls.letter);
    j_use     = useful_cnt_r + LEN_W'(cls.printable && cls.useful);
    j_start   = start_now ? byte_offset_r : run_start_r;
    j_prefix  = prefix_r;
    if (cls.printable && (run_len_r < LEN_W'(PREFIX_BYTES))) begin
      j_prefix = prefix_r | (32'(s_byte_r) << {run_len_r[1:0], 3'b000});
    end
    hit_max   = cls.printable && (len_inc >= LEN_W'(MAX_RUN_LENGTH));
    close_run = (j_len != '0) && (s_last_r || !cls.printable || hit_max);
  end

  // Judge the closing run.
  always_comb begin
    use_scaled = PROD_W'(j_use) * PROD_W'(PERCENT_SCALE);
    len_scaled = PROD_W'(j_len) * PROD_W'(useful_percent_r);
    qualifies  = (CMP_W'(j_len) >= CMP_W'(min_length_r)) &&
                 (CMP_W'(j_let) >= CMP_W'(min_letters_r)) &&
                 (use_scaled >= len_scaled);
    report     = close_run && qualifies;
    rtti       = (j_len >= LEN_W'(PREFIX_BYTES)) &&
                 ((j_prefix == RTTI_CLASS_TAG) || (j_prefix == RTTI_STRUCT_TAG));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r   <= BASE_ADDRESS_RST;
      min_length_r     <= MIN_LENGTH_RST;
      min_letters_r    <= MIN_LETTERS_RST;
      useful_percent_r <= USEFUL_PERCENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BASE_ADDRESS:   base_address_r   <= cfg_data[ADDR_W-1:0];
        CFG_MIN_LENGTH:     min_length_r     <= cfg_data[MIN_LEN_W-1:0];
        CFG_MIN_LETTERS:    min_letters_r    <= cfg_data[MIN_LET_W-1:0];
        CFG_USEFUL_PERCENT: useful_percent_r <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s_valid_r <= 1'b1;
    end else if (adv) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_byte_r <= in_tdata;
      s_last_r <= in_tlast;
    end
  end

  // Run state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      run_start_r   <= '0;
      run_len_r     <= '0;
      letter_cnt_r  <= '0;
      useful_cnt_r  <= '0;
      prefix_r      <= '0;
    end else if (adv) begin
      byte_offset_r <= s_last_r ? '0 : byte_offset_r + ADDR_W'(1);
      if (close_run || s_last_r) begin
        run_start_r  <= '0;
        run_len_r    <= '0;
        letter_cnt_r <= '0;
        useful_cnt_r <= '0;
        prefix_r     <= '0;
      end else begin
        run_start_r  <= j_start;
        run_len_r    <= j_len;
        letter_cnt_r <= j_let;
        useful_cnt_r <= j_use;
        prefix_r     <= j_prefix;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && report) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && report) begin
      out_addr_r <= base_address_r + j_start;
      out_len_r  <= STR_LEN_W'(j_len);
      out_rtti_r <= rtti;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - ADDR_W - STR_LEN_W){1'b0}}, out_len_r, out_addr_r};
  assign out_tuser  = out_rtti_r;

  // An open run never holds the maximum length; it is closed on reaching it.
  `PRSD_ASSERT_IMPL(a_run_below_max, 1'b1, run_len_r < LEN_W'(MAX_RUN_LENGTH))
  // Letters are a subset of useful characters, which are a subset of the run.
  `PRSD_ASSERT_IMPL(a_cnt_order, 1'b1, letter_cnt_r <= useful_cnt_r && useful_cnt_r <= run_len_r)
  // The last byte of a section leaves the offset and run cleared.
  `PRSD_ASSERT_NEXT(a_last_clears, adv && s_last_r, (byte_offset_r == '0) && (run_len_r == '0))
  // With the output register empty the block always takes a new byte.
  `PRSD_ASSERT_IMPL(a_ready_when_empty, !out_valid_r, in_tready)
  // A reported run is never empty.
  `PRSD_ASSERT_IMPL(a_report_nonempty, adv && report, j_len != '0)

endmodule

FILE: src/prsd_char_class.sv
// Character classifier: printable, letter and useful flags for one byte.
// Depends on prsd_pkg.
module prsd_char_class
  import prsd_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_i,
  output char_class_t       cls_o
);

  logic letter;
  logic digit;
  logic punct;

  // Letters and digits are plain range checks.
  assign letter = ((byte_i >= "A") && (byte_i <= "Z")) ||
                  ((byte_i >= "a") && (byte_i <= "z"));
  assign digit  = (byte_i >= "0") && (byte_i <= "9");

  // Punctuation that still counts as useful text.
  always_comb begin
    unique case (byte_i)
      " ", "_", ":", ".", "/", "\\", "-", "(", ")", "%", "$", "[", "]": punct = 1'b1;
      default: punct = 1'b0;
    endcase
  end

  assign cls_o.printable = (byte_i >= PRINT_LO) && (byte_i <= PRINT_HI);
  assign cls_o.letter    = letter;
  assign cls_o.useful    = letter || digit || punct;

endmodule

FILE: tb/sv/prsd_run_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the printable string run detector: it watches the byte, result and
// register channels, predicts each reported run and compares it. Depends on prsd_pkg.
module prsd_run_checker
  import prsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending_runs
);

  // Name prefixes of type descriptors, first character in the low byte.
  localparam logic [31:0] CLASS_NAME_PREFIX  = {8'h56, 8'h41, 8'h3F, 8'h2E};
  localparam logic [31:0] STRUCT_NAME_PREFIX = {8'h55, 8'h41, 8'h3F, 8'h2E};

  typedef struct packed {
    logic [31:0] address;
    logic [8:0]  length;
    logic        rtti;
  } run_report_t;

  run_report_t expected_runs[$];

  // Shadow of the registers.
  logic [31:0] base_address_q;
  logic [8:0]  min_length_q;
  logic [8:0]  min_letters_q;
  logic [6:0]  useful_percent_q;

  // Shadow of the scan state.
  logic [31:0] offset_q;
  logic [31:0] start_q;
  logic [31:0] prefix_q;
  int          run_len_q;
  int          letters_q;
  int          useful_q;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_useful(logic [7:0] c);
    if (is_letter(c) || (c >= 8'h30 && c <= 8'h39)) return 1'b1;
    case (c)
      " ", "_", ":", ".", "/", "\\", "-", "(", ")", "%", "$", "[", "]": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void forget_run();
    start_q   = '0;
    prefix_q  = '0;
    run_len_q = 0;
    letters_q = 0;
    useful_q  = 0;
  endfunction

  // Judges the open run, queues a report if it qualifies, and closes it.
  function automatic void close_run();
    run_report_t rep;
    if (run_len_q > 0 && run_len_q >= int'(min_length_q) &&
        letters_q >= int'(min_letters_q) &&
        longint'(useful_q) * 100 >= longint'(run_len_q) * longint'(useful_percent_q)) begin
      rep.address = base_address_q + start_q;
      rep.length  = run_len_q[8:0];
      rep.rtti    = run_len_q >= 4 &&
                    (prefix_q == CLASS_NAME_PREFIX || prefix_q == STRUCT_NAME_PREFIX);
      expected_runs.insert(expected_runs.size(), rep);
    end
    forget_run();
  endfunction

  // Advances the scan state by one byte.
  function automatic void scan_byte(logic [7:0] c, logic last);
    if (c >= 8'h20 && c <= 8'h7E) begin
      if (run_len_q == 0) begin
        forget_run();
        start_q = offset_q;
      end
      if (is_letter(c)) letters_q++;
      if (is_useful(c)) useful_q++;
      if (run_len_q < 4) prefix_q[8*run_len_q +: 8] = c;
      run_len_q++;
      if (run_len_q >= MAX_RUN_LENGTH) close_run();
    end else if (run_len_q > 0) begin
      close_run();
    end
    if (last && run_len_q > 0) close_run();
    if (last) begin
      offset_q = '0;
      forget_run();
    end else begin
      offset_q = offset_q + 1;
    end
  endfunction

  always @(posedge clk) begin
    run_report_t want;
    int          errs;
    if (!rst_n) begin
      base_address_q   = '0;
      min_length_q     = 9'd6;
      min_letters_q    = 9'd3;
      useful_percent_q = 7'd70;
      offset_q         = '0;
      forget_run();
      expected_runs.delete();
      fail_count      <= 0;
    end else begin
      errs = 0;
      // Results are compared first: a byte taken at this edge cannot report yet.
      if (out_tvalid && out_tready) begin
        if (expected_runs.size() == 0) begin
          $display("%0t: unexpected run: expected none, actual addr=%h len=%0d rtti=%0b",
                   $time, out_tdata[31:0], out_tdata[40:32], out_tuser);
          errs++;
        end else begin
          want = expected_runs.pop_front();
          if (out_tdata[31:0] !== want.address) begin
            $display("%0t: string_address mismatch: expected %h, actual %h",
                     $time, want.address, out_tdata[31:0]);
            errs++;
          end
          if (out_tdata[40:32] !== want.length) begin
            $display("%0t: string_length mismatch: expected %0d, actual %0d",
                     $time, want.length, out_tdata[40:32]);
            errs++;
          end
          if (out_tuser !== want.rtti) begin
            $display("%0t: is_rtti mismatch: expected %0b, actual %0b",
                     $time, want.rtti, out_tuser);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;

      // Register writes are to be made only while the block is idle; the block does not enforce it.
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BASE_ADDRESS:   base_address_q   = cfg_data[31:0];
          CFG_MIN_LENGTH:     min_length_q     = cfg_data[8:0];
          CFG_MIN_LETTERS:    min_letters_q    = cfg_data[8:0];
          CFG_USEFUL_PERCENT: useful_percent_q = cfg_data[6:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
    end
    pending_runs <= expected_runs.size();
  end

endmodule

FILE: tb/sv/tb_printable_string_run_detector_unit.sv
`timescale 1ns / 100ps
// Top of the printable string run detector testbench: clock, reset, byte stimulus,
// register phases and the verdict. Depends on prsd_pkg, the block and prsd_run_checker.
module tb_printable_string_run_detector_unit
  import prsd_pkg::*;
();

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 200;
  localparam int CYCLE_LIMIT   = 400000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int pending_runs;
  int items_sent = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_off_req = 1'b0;
  bit hold_taken = 1'b0;

  printable_string_run_detector_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  prsd_run_checker run_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_runs (pending_runs)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_printable_string_run_detector_unit: FAIL");
      $finish;
    end
  end

  // Result side: random stalls, and on request one long hold-off.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != hold_taken) begin
        hold_taken = hold_off_req;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offers one item, idling first at the sender's rate; valid stays high afterwards.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_text(string s, bit last_on_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], last_on_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] letter_byte();
    logic [7:0] b;
    b = 8'($urandom_range(25));
    return ($urandom_range(1) ? 8'h41 : 8'h61) + b;
  endfunction

  // Mostly useful characters, sometimes any printable one.
  function automatic logic [7:0] text_byte();
    string punct;
    int    r;
    logic [7:0] b;
    punct = " _:./\\-()%$[]";
    r = $urandom_range(99);
    if (r < 45) return letter_byte();
    if (r < 60) begin
      b = 8'($urandom_range(9));
      return 8'h30 + b;
    end
    if (r < 80) return punct[$urandom_range(punct.len() - 1)];
    b = 8'($urandom_range(8'h7E, 8'h20));
    return b;
  endfunction

  function automatic logic [7:0] control_byte();
    logic [7:0] b;
    if ($urandom_range(1)) b = 8'($urandom_range(8'h1F));
    else b = 8'($urandom_range(8'hFF, 8'h7F));
    return b;
  endfunction

  // A printable run; some open with a type-descriptor prefix or a near miss of one.
  task automatic send_run(int len, bit clean, bit last_on_end);
    int          tag;
    logic [31:0] prefix;
    logic [7:0]  b;
    tag = $urandom_range(9);
    prefix = {(tag == 0) ? 8'h56 : (tag == 1) ? 8'h55 : 8'h57, 8'h41, 8'h3F, 8'h2E};
    for (int i = 0; i < len; i++) begin
      if (!clean && tag < 3 && i < 4) b = prefix[8*i +: 8];
      else if (clean) b = ($urandom_range(9) != 0) ? letter_byte() : 8'h30 + 8'($urandom_range(9));
      else b = text_byte();
      send_byte(b, last_on_end && i == len - 1);
    end
  endtask

  // One stretch of the section: noise, or a run and how it ends.
  task automatic send_segment(bit want_long);
    int len;
    int term;
    if (!want_long && $urandom_range(99) < 25) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), $urandom_range(11) == 0);
    end else begin
      if (want_long) len = $urandom_range(300, 256);
      else if ($urandom_range(99) < 2) len = $urandom_range(300, 250);
      else len = $urandom_range(16, 1);
      term = $urandom_range(99);
      send_run(len, want_long, term < 30);
      if (term >= 30 && term < 80) send_byte(control_byte(), $urandom_range(9) == 0);
    end
  endtask

  // Waits until every expected run has come out and the pipeline is empty.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_runs != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic run_phase(logic [31:0] base, int min_len, int min_let, int pct,
                           int sidle, int rstall, int budget, bit with_long, bit with_hold);
    int start_count;
    wait_for_results();
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_MIN_LENGTH, min_len);
    write_reg(CFG_MIN_LETTERS, min_let);
    write_reg(CFG_USEFUL_PERCENT, pct);
    cfg_valid <= 1'b0;
    sender_idle_pct    = sidle;
    receiver_stall_pct = rstall;
    start_count = items_sent;
    // Short reportable runs back to back while the result side holds off.
    if (with_hold) begin
      hold_off_req = ~hold_off_req;
      repeat (30) begin
        send_text("ab", 1'b0);
        send_byte(8'h00, 1'b0);
      end
    end
    if (with_long) send_segment(1'b1);
    while (items_sent - start_count < budget) send_segment(1'b0);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed bytes under the reset settings: plain runs, both descriptor
    // prefixes, printable extremes, and a run closed by the section's last byte.
    send_text("Hi you", 1'b0);
    send_byte(8'h7F, 1'b0);
    send_text(".?AVab", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text(".?AUcd", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_text("Qzy0_9", 1'b1);

    // Register phases, each with its own settings and an idling pattern.
    run_phase(32'h0000_1000, 6, 3, 70, 0, 0, 230, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFF0, 2, 0, 0, 71, 0, 230, 1'b0, 1'b0);
    run_phase($urandom, 256, 200, 100, 0, 71, 230, 1'b1, 1'b0);
    run_phase($urandom, $urandom_range(12, 2), $urandom_range(4), $urandom_range(90, 30),
              16, 16, 230, 1'b0, 1'b0);
    run_phase($urandom, 1, 0, 100, 0, 0, 230, 1'b0, 1'b0);
    run_phase($urandom, 0, 256, 127, 71, 71, 150, 1'b0, 1'b0);
    run_phase($urandom, 2, 0, 0, 0, 16, 150, 1'b0, 1'b1);
    run_phase($urandom, $urandom_range(256, 2), $urandom_range(256), $urandom_range(100),
              16, 16, 200, 1'b0, 1'b0);
    wait_for_results();

    if (fail_count == 0) begin
      $display("tb_printable_string_run_detector_unit: PASS");
    end else begin
      $display("tb_printable_string_run_detector_unit: FAIL");
    end
    $finish;
  end

endmodule
